FILE: sv/frl_pkg.sv
// Shared types, widths and constants of the Fresnel reflectance pipeline.
`default_nettype none
package frl_pkg;

	localparam int FRAC_BITS = 14;
	localparam int IN_W      = 16;
	localparam int IOR_W     = 16;
	localparam int TWO_F     = 2 * FRAC_BITS;
	localparam int DOT_W     = 2 * IN_W + 2;
	localparam int CMP_W     = (TWO_F + 1 > DOT_W) ? TWO_F + 1 : DOT_W;
	localparam int SH_R      = (TWO_F >= 30) ? TWO_F - 30 : 0;
	localparam int SH_L      = (TWO_F >= 30) ? 0 : 30 - TWO_F;

	localparam int ROOT_W    = 31;
	localparam int RAD_W     = 61;
	localparam int REM_W     = 62;
	localparam int SQ_W      = 62;
	localparam int PROD_W    = IOR_W + ROOT_W;
	localparam int SIN_W     = 30;
	localparam int RR_W      = 32;
	localparam int RQ_W      = 16;
	localparam int DEN_W     = PROD_W + 1;
	localparam int RATIO_W   = 18;
	localparam int DV_W      = DEN_W + RATIO_W;
	localparam int KR_W      = 16;

	localparam logic [CMP_W-1:0] ONE_IN    = CMP_W'(1) << TWO_F;
	localparam logic [RAD_W-1:0] ONE_Q60   = RAD_W'(1) << 60;
	localparam logic [KR_W-1:0]  KR_ONE    = 16'h8000;
	localparam logic [RQ_W-1:0]  REL_SAT   = 16'hFFFF;

	// Operands and flags that ride along with an item through the pipeline.
	typedef struct packed {
		logic [IOR_W-1:0]  n_in;
		logic [IOR_W-1:0]  n_out;
		logic [ROOT_W-1:0] cos_i;
		logic              tir;
		logic [RQ_W-1:0]   rel;
	} pipe_t;

	typedef struct packed {
		logic [KR_W-1:0] kr;
		logic            tir;
		logic [RQ_W-1:0] rel;
	} res_t;

	// Brings a clamped dot product magnitude to Q30.
	function automatic logic [ROOT_W-1:0] to_q30(input logic [CMP_W-1:0] m);
		logic [CMP_W-1:0] t;
		t = (m >> SH_R) << SH_L;
		return t[ROOT_W-1:0];
	endfunction

endpackage
`default_nettype wire

FILE: sv/frl_front.sv
// Front stages: dot product, clamp, index selection and cosine square.
`default_nettype none
module frl_front import frl_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic signed [IN_W-1:0]  normal_x,
	input  logic signed [IN_W-1:0]  normal_y,
	input  logic signed [IN_W-1:0]  normal_z,
	input  logic signed [IN_W-1:0]  dir_x,
	input  logic signed [IN_W-1:0]  dir_y,
	input  logic signed [IN_W-1:0]  dir_z,
	input  logic [IOR_W-1:0]        surround_index,
	input  logic [IOR_W-1:0]        object_index,
	output logic                    out_valid,
	output logic [RAD_W-1:0]        rad,
	output pipe_t                   side_out
);

	logic                    v_s1, v_s2, v_s3;
	logic signed [2*IN_W-1:0] px_s1, py_s1, pz_s1;
	logic [IOR_W-1:0]        sur_s1, obj_s1;
	pipe_t                   side_s2, side_s3;
	logic [SQ_W-1:0]         sq_s3;

	logic signed [DOT_W-1:0] dot;
	logic                    neg;
	logic [DOT_W-1:0]        mag;
	logic [CMP_W-1:0]        mag_w, mag_c;
	logic [IOR_W-1:0]        sur_fix, obj_fix;
	pipe_t                   side_c;

	always_comb begin
		dot   = DOT_W'(px_s1) + DOT_W'(py_s1) + DOT_W'(pz_s1);
		neg   = dot < 0;
		mag   = neg ? DOT_W'(-dot) : DOT_W'(dot);
		mag_w = CMP_W'(mag);
		mag_c = (mag_w > ONE_IN) ? ONE_IN : mag_w;
		// An index code of zero is taken as one so no index divisor is ever zero.
		sur_fix = (sur_s1 == '0) ? IOR_W'(1) : sur_s1;
		obj_fix = (obj_s1 == '0) ? IOR_W'(1) : obj_s1;
		side_c.n_out = neg ? obj_fix : sur_fix;
		side_c.n_in  = neg ? sur_fix : obj_fix;
		side_c.cos_i = to_q30(mag_c);
		side_c.tir   = 1'b0;
		side_c.rel   = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1   <= (2*IN_W)'(normal_x) * (2*IN_W)'(dir_x);
			py_s1   <= (2*IN_W)'(normal_y) * (2*IN_W)'(dir_y);
			pz_s1   <= (2*IN_W)'(normal_z) * (2*IN_W)'(dir_z);
			sur_s1  <= surround_index;
			obj_s1  <= object_index;
			side_s2 <= side_c;
			side_s3 <= side_s2;
			sq_s3   <= SQ_W'(side_s2.cos_i) * SQ_W'(side_s2.cos_i);
		end
	end

	assign out_valid = v_s3;
	assign rad       = ONE_Q60 - sq_s3[RAD_W-1:0];
	assign side_out  = side_s3;

endmodule
`default_nettype wire

FILE: sv/frl_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module frl_sqrt import frl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [RAD_W-1:0]  rad,
	input  pipe_t             side_in,
	output logic              out_valid,
	output logic [ROOT_W-1:0] root,
	output pipe_t             side_out
);

	localparam int NS = ROOT_W;

	logic             v_s    [NS];
	logic [REM_W-1:0] rem_s  [NS];
	logic [REM_W-1:0] res_s  [NS];
	pipe_t            side_s [NS];

	for (genvar k = 0; k < NS; k++) begin : g_st
		localparam int B = NS - 1 - k;
		logic [REM_W-1:0] rem_i, res_i, bitv, trial, rem_o, res_o;
		pipe_t            side_i;
		logic             v_i;

		if (k == 0) begin : g_first
			assign rem_i  = REM_W'(rad);
			assign res_i  = '0;
			assign side_i = side_in;
			assign v_i    = in_valid;
		end else begin : g_next
			assign rem_i  = rem_s[k-1];
			assign res_i  = res_s[k-1];
			assign side_i = side_s[k-1];
			assign v_i    = v_s[k-1];
		end

		always_comb begin
			bitv  = REM_W'(1) << (2 * B);
			trial = res_i + bitv;
			if (rem_i >= trial) begin
				rem_o = rem_i - trial;
				res_o = (res_i >> 1) + bitv;
			end else begin
				rem_o = rem_i;
				res_o = res_i >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= rem_o;
				res_s[k]  <= res_o;
				side_s[k] <= side_i;
			end
		end
	end

	assign out_valid = v_s[NS-1];
	assign root      = res_s[NS-1][ROOT_W-1:0];
	assign side_out  = side_s[NS-1];

endmodule
`default_nettype wire

FILE: sv/frl_snell.sv
// Snell stages: sin_t by long division, total reflection test, relative index.
`default_nettype none
module frl_snell import frl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [ROOT_W-1:0] sin_i,
	input  pipe_t             side_in,
	output logic              out_valid,
	output logic [RAD_W-1:0]  rad,
	output pipe_t             side_out
);

	localparam int ND = SIN_W;

	logic              v_s1, v_sq;
	logic [PROD_W-1:0] prod_s1;
	logic [RR_W-1:0]   rdiv_s1;
	pipe_t             side_s1, side_sq;
	logic [SQ_W-1:0]   sq_sq;

	logic              v_s    [ND];
	logic [PROD_W-1:0] rem_s  [ND];
	logic [SIN_W-1:0]  q_s    [ND];
	logic [RR_W-1:0]   rr_s   [ND];
	logic [RQ_W-1:0]   rq_s   [ND];
	logic              rsat_s [ND];
	pipe_t             side_s [ND];

	for (genvar k = 0; k < ND; k++) begin : g_div
		localparam int J = ND - 1 - k;
		logic [PROD_W-1:0] rem_i, rem_o, dsh;
		logic [SIN_W-1:0]  q_i, q_o;
		logic [RR_W-1:0]   rr_i, rr_o, rsh;
		logic [RQ_W-1:0]   rq_i, rq_o;
		logic              rsat_i, v_i;
		pipe_t             side_i;

		if (k == 0) begin : g_first
			always_comb begin
				rem_i      = prod_s1;
				q_i        = '0;
				rr_i       = rdiv_s1;
				rq_i       = '0;
				rsat_i     = rdiv_s1 >= {side_s1.n_out, 16'b0};
				side_i     = side_s1;
				// sin_t would reach one: the quotient is not needed.
				side_i.tir = prod_s1 >= {side_s1.n_in, 30'b0};
				v_i        = v_s1;
			end
		end else begin : g_next
			assign rem_i  = rem_s[k-1];
			assign q_i    = q_s[k-1];
			assign rr_i   = rr_s[k-1];
			assign rq_i   = rq_s[k-1];
			assign rsat_i = rsat_s[k-1];
			assign side_i = side_s[k-1];
			assign v_i    = v_s[k-1];
		end

		always_comb begin
			dsh  = PROD_W'(side_i.n_in) << J;
			rem_o = rem_i;
			q_o   = q_i;
			if (rem_i >= dsh) begin
				rem_o = rem_i - dsh;
				q_o   = q_i | (SIN_W'(1) << J);
			end
			rsh  = RR_W'(side_i.n_out) << J;
			rr_o = rr_i;
			rq_o = rq_i;
			if (J < RQ_W && rr_i >= rsh) begin
				rr_o = rr_i - rsh;
				rq_o = rq_i | RQ_W'(RR_W'(1) << J);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= rem_o;
				q_s[k]    <= q_o;
				rr_s[k]   <= rr_o;
				rq_s[k]   <= rq_o;
				rsat_s[k] <= rsat_i;
				side_s[k] <= side_i;
			end
		end
	end

	logic [SIN_W-1:0] sin_t;
	pipe_t            side_l;

	always_comb begin
		sin_t      = side_s[ND-1].tir ? '0 : q_s[ND-1];
		side_l     = side_s[ND-1];
		side_l.rel = rsat_s[ND-1] ? REL_SAT : rq_s[ND-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_sq <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_sq <= v_s[ND-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= PROD_W'(side_in.n_out) * PROD_W'(sin_i);
			rdiv_s1 <= (RR_W'(side_in.n_in) << 13) + RR_W'(side_in.n_out >> 1);
			side_s1 <= side_in;
			sq_sq   <= SQ_W'(sin_t) * SQ_W'(sin_t);
			side_sq <= side_l;
		end
	end

	assign out_valid = v_sq;
	assign rad       = ONE_Q60 - sq_sq[RAD_W-1:0];
	assign side_out  = side_sq;

endmodule
`default_nettype wire

FILE: sv/frl_ratio.sv
// Back stages: amplitude ratios by long division and the mean of their squares.
`default_nettype none
module frl_ratio import frl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [ROOT_W-1:0] cos_t,
	input  pipe_t             side_in,
	output logic              out_valid,
	output res_t              res_out
);

	localparam int ND = RATIO_W;

	logic              v_m, v_n, v_q, v_f;
	logic [PROD_W-1:0] p1_m, q1_m, p2_m, q2_m;
	logic              tir_m, tir_n, tir_q;
	logic [RQ_W-1:0]   rel_m, rel_n, rel_q;
	logic [DV_W-1:0]   a_dv_n, b_dv_n;
	logic [DEN_W-1:0]  a_den_n, b_den_n;
	logic              bad_n, bad_q;
	logic [2*RATIO_W-1:0] a_sq_q, b_sq_q;
	res_t              res_f;

	logic [PROD_W-1:0] a_num, b_num;
	logic [DEN_W-1:0]  a_den, b_den;

	always_comb begin
		a_num = (p1_m >= q1_m) ? p1_m - q1_m : q1_m - p1_m;
		b_num = (p2_m >= q2_m) ? p2_m - q2_m : q2_m - p2_m;
		a_den = DEN_W'(p1_m) + DEN_W'(q1_m);
		b_den = DEN_W'(p2_m) + DEN_W'(q2_m);
	end

	logic             v_s     [ND];
	logic [DV_W-1:0]  a_rem_s [ND];
	logic [DV_W-1:0]  b_rem_s [ND];
	logic [DEN_W-1:0] a_den_s [ND];
	logic [DEN_W-1:0] b_den_s [ND];
	logic [RATIO_W-1:0] a_q_s [ND];
	logic [RATIO_W-1:0] b_q_s [ND];
	logic             bad_s   [ND];
	logic             tir_s   [ND];
	logic [RQ_W-1:0]  rel_s   [ND];

	for (genvar k = 0; k < ND; k++) begin : g_div
		localparam int J = ND - 1 - k;
		logic [DV_W-1:0]    a_rem_i, b_rem_i, a_rem_o, b_rem_o, a_sh, b_sh;
		logic [DEN_W-1:0]   a_den_i, b_den_i;
		logic [RATIO_W-1:0] a_q_i, b_q_i, a_q_o, b_q_o;
		logic               bad_i, tir_i, v_i;
		logic [RQ_W-1:0]    rel_i;

		if (k == 0) begin : g_first
			assign a_rem_i = a_dv_n;
			assign b_rem_i = b_dv_n;
			assign a_den_i = a_den_n;
			assign b_den_i = b_den_n;
			assign a_q_i   = '0;
			assign b_q_i   = '0;
			assign bad_i   = bad_n;
			assign tir_i   = tir_n;
			assign rel_i   = rel_n;
			assign v_i     = v_n;
		end else begin : g_next
			assign a_rem_i = a_rem_s[k-1];
			assign b_rem_i = b_rem_s[k-1];
			assign a_den_i = a_den_s[k-1];
			assign b_den_i = b_den_s[k-1];
			assign a_q_i   = a_q_s[k-1];
			assign b_q_i   = b_q_s[k-1];
			assign bad_i   = bad_s[k-1];
			assign tir_i   = tir_s[k-1];
			assign rel_i   = rel_s[k-1];
			assign v_i     = v_s[k-1];
		end

		always_comb begin
			a_sh    = DV_W'(a_den_i) << J;
			b_sh    = DV_W'(b_den_i) << J;
			a_rem_o = a_rem_i;
			b_rem_o = b_rem_i;
			a_q_o   = a_q_i;
			b_q_o   = b_q_i;
			if (a_rem_i >= a_sh) begin
				a_rem_o = a_rem_i - a_sh;
				a_q_o   = a_q_i | (RATIO_W'(1) << J);
			end
			if (b_rem_i >= b_sh) begin
				b_rem_o = b_rem_i - b_sh;
				b_q_o   = b_q_i | (RATIO_W'(1) << J);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				a_rem_s[k] <= a_rem_o;
				b_rem_s[k] <= b_rem_o;
				a_den_s[k] <= a_den_i;
				b_den_s[k] <= b_den_i;
				a_q_s[k]   <= a_q_o;
				b_q_s[k]   <= b_q_o;
				bad_s[k]   <= bad_i;
				tir_s[k]   <= tir_i;
				rel_s[k]   <= rel_i;
			end
		end
	end

	logic [2*RATIO_W:0] sum;
	logic [RATIO_W-2:0] kr_raw;
	res_t               res_c;

	always_comb begin
		sum    = (2*RATIO_W+1)'(a_sq_q) + (2*RATIO_W+1)'(b_sq_q)
			+ (2*RATIO_W+1)'(1 << 19);
		kr_raw = sum[2*RATIO_W:20];
		res_c.tir = tir_q;
		res_c.rel = rel_q;
		// A zero ratio divisor cannot happen below total reflection; kept safe anyway.
		if (tir_q || bad_q || kr_raw > (RATIO_W-1)'(KR_ONE)) begin
			res_c.kr = KR_ONE;
		end else begin
			res_c.kr = kr_raw[KR_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m <= 1'b0;
			v_n <= 1'b0;
			v_q <= 1'b0;
			v_f <= 1'b0;
		end else if (en) begin
			v_m <= in_valid;
			v_n <= v_m;
			v_q <= v_s[ND-1];
			v_f <= v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p1_m    <= PROD_W'(side_in.n_in) * PROD_W'(side_in.cos_i);
			q1_m    <= PROD_W'(side_in.n_out) * PROD_W'(cos_t);
			p2_m    <= PROD_W'(side_in.n_out) * PROD_W'(side_in.cos_i);
			q2_m    <= PROD_W'(side_in.n_in) * PROD_W'(cos_t);
			tir_m   <= side_in.tir;
			rel_m   <= side_in.rel;
			a_dv_n  <= (DV_W'(a_num) << 17) + DV_W'(a_den >> 1);
			b_dv_n  <= (DV_W'(b_num) << 17) + DV_W'(b_den >> 1);
			a_den_n <= a_den;
			b_den_n <= b_den;
			bad_n   <= (a_den == '0) || (b_den == '0);
			tir_n   <= tir_m;
			rel_n   <= rel_m;
			a_sq_q  <= (2*RATIO_W)'(a_q_s[ND-1]) * (2*RATIO_W)'(a_q_s[ND-1]);
			b_sq_q  <= (2*RATIO_W)'(b_q_s[ND-1]) * (2*RATIO_W)'(b_q_s[ND-1]);
			bad_q   <= bad_s[ND-1];
			tir_q   <= tir_s[ND-1];
			rel_q   <= rel_s[ND-1];
			res_f   <= res_c;
		end
	end

	assign out_valid = v_f;
	assign res_out   = res_f;

endmodule
`default_nettype wire

FILE: sv/fresnel_reflectance.sv
// Top level of the unpolarized Fresnel reflectance pipeline.
//
// Input channel: in_valid/in_stall with a surface normal, a ray direction
// (Q1.14 signed) and the surrounding and object indices (Q3.13). An item is
// taken at a clock edge where in_valid is high and in_stall is low.
// Output channel: out_valid/out_stall with reflectance (Q1.15), the total
// internal reflection flag and the relative index n_in/n_out (Q3.13).
// Throughput is one item per clock while in_stall is low. The pipeline
// depth comes from two bit-serial square root chains of 31 stages each
// and two division chains of 30 and 18 stages.
// Reset clears every valid bit, so the pipeline and output are empty.
// When the receiver stalls, the output register holds its item and a skid
// register catches the next one; only then does in_stall rise and the whole
// pipeline freeze, and nothing is lost or repeated.
`default_nettype none
module fresnel_reflectance import frl_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic signed [IN_W-1:0] normal_x,
	input  logic signed [IN_W-1:0] normal_y,
	input  logic signed [IN_W-1:0] normal_z,
	input  logic signed [IN_W-1:0] dir_x,
	input  logic signed [IN_W-1:0] dir_y,
	input  logic signed [IN_W-1:0] dir_z,
	input  logic [IOR_W-1:0]       surround_index,
	input  logic [IOR_W-1:0]       object_index,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [KR_W-1:0]        reflectance,
	output logic                   total_internal,
	output logic [RQ_W-1:0]        relative_index
);

	logic              en;
	logic              f_v, s1_v, sn_v, s2_v, p_v;
	logic [RAD_W-1:0]  f_rad, sn_rad;
	logic [ROOT_W-1:0] sin_i, cos_t;
	pipe_t             f_side, s1_side, sn_side, s2_side;
	res_t              p_res;

	logic out_v_q, sk_v_q;
	res_t out_q, sk_q;

	assign en = !sk_v_q;

	frl_front u_front (
		.clk, .arst_n, .en, .in_valid,
		.normal_x, .normal_y, .normal_z, .dir_x, .dir_y, .dir_z,
		.surround_index, .object_index,
		.out_valid (f_v),
		.rad       (f_rad),
		.side_out  (f_side)
	);

	frl_sqrt u_sqrt_sin (
		.clk, .arst_n, .en,
		.in_valid  (f_v),
		.rad       (f_rad),
		.side_in   (f_side),
		.out_valid (s1_v),
		.root      (sin_i),
		.side_out  (s1_side)
	);

	frl_snell u_snell (
		.clk, .arst_n, .en,
		.in_valid  (s1_v),
		.sin_i     (sin_i),
		.side_in   (s1_side),
		.out_valid (sn_v),
		.rad       (sn_rad),
		.side_out  (sn_side)
	);

	frl_sqrt u_sqrt_cos (
		.clk, .arst_n, .en,
		.in_valid  (sn_v),
		.rad       (sn_rad),
		.side_in   (sn_side),
		.out_valid (s2_v),
		.root      (cos_t),
		.side_out  (s2_side)
	);

	frl_ratio u_ratio (
		.clk, .arst_n, .en,
		.in_valid  (s2_v),
		.cos_t     (cos_t),
		.side_in   (s2_side),
		.out_valid (p_v),
		.res_out   (p_res)
	);

	// The pipeline moves only while the skid register is empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			sk_v_q  <= 1'b0;
		end else if (!out_v_q || !out_stall) begin
			out_v_q <= sk_v_q || p_v;
			sk_v_q  <= 1'b0;
		end else if (!sk_v_q && p_v) begin
			sk_v_q  <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || !out_stall) begin
			out_q <= sk_v_q ? sk_q : p_res;
		end else if (!sk_v_q) begin
			sk_q  <= p_res;
		end
	end

	assign in_stall       = sk_v_q;
	assign out_valid      = out_v_q;
	assign reflectance    = out_q.kr;
	assign total_internal = out_q.tir;
	assign relative_index = out_q.rel;

endmodule
`default_nettype wire

FILE: sv/frl_chk.sv
// Port-level checker for the Fresnel reflectance block and its binding.
`default_nettype none
module frl_chk import frl_pkg::*; (
	input logic            clk,
	input logic            arst_n,
	input logic            in_stall,
	input logic            out_valid,
	input logic            out_stall,
	input logic [KR_W-1:0] reflectance,
	input logic            total_internal,
	input logic [RQ_W-1:0] relative_index
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(reflectance)
			&& $stable(total_internal) && $stable(relative_index))
		else $error("stalled output item changed");

	a_tir_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && total_internal |-> reflectance == KR_ONE)
		else $error("total reflection without unit reflectance");

	a_kr_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> reflectance <= KR_ONE)
		else $error("reflectance above one");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(out_valid && out_stall))
		else $error("input stalled without a stalled output");

endmodule

bind fresnel_reflectance frl_chk u_frl_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.reflectance    (reflectance),
	.total_internal (total_internal),
	.relative_index (relative_index)
);
`default_nettype wire
